// ----- hdl/fbba_pkg.sv -----
// ----------------------------------------------------------------------------
// fbba_pkg
// Shared constants, codes, state type and control/status bundles of the
// file block bitmap allocator.
// ----------------------------------------------------------------------------
package fbba_pkg;

    // sizing
    localparam int DATA_BLOCKS = 1024;
    localparam int FILES       = 64;
    localparam int POINTERS    = 5;

    // free bitmap organised as words of WORD_W bits
    localparam int WORD_W    = 32;
    localparam int MAP_WORDS = DATA_BLOCKS / WORD_W;
    localparam int MAP_AW    = $clog2(MAP_WORDS);
    localparam int BIT_AW    = $clog2(WORD_W);
    localparam int WIDX_W    = MAP_AW + 1;

    // field widths
    localparam int OP_W      = 2;
    localparam int FILE_W    = 6;
    localparam int LEN_W     = 16;
    localparam int BS_W      = 13;
    localparam int LIM_W     = 11;
    localparam int BLK_W     = 10;
    localparam int STATUS_W  = 2;
    localparam int FSIZE_W   = 15;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 13;

    // file size and pointer stores
    localparam int FS_AW     = $clog2(FILES);
    localparam int PTR_DEPTH = FILES * POINTERS;
    localparam int PTR_AW    = $clog2(PTR_DEPTH);
    localparam int K_W       = $clog2(POINTERS + 1);

    // configuration limits and reset values
    localparam int BS_MAX       = 4096;
    localparam int BS_RESET     = 2048;
    localparam int USABLE_RESET = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_LARGE = 2'd1,
        STATUS_NO_SPACE  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE = 1'b0,
        CFG_USABLE     = 1'b1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FS_RD,
        S_SIZE_LD,
        S_REL_CHK,
        S_REL_PTR,
        S_REL_MAP,
        S_REL_DONE,
        S_LEN_CHK,
        S_NEED,
        S_SCAN_RD,
        S_SCAN_LD,
        S_SCAN_PICK,
        S_CLAIM_INIT,
        S_CLAIM_RD,
        S_CLAIM_WR,
        S_CLAIM_EMIT,
        S_RD_CHK,
        S_RD_EMIT,
        S_EMIT_IDLE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;          // take the input item
        logic fs_rd;         // read file size entry
        logic size_ld;       // remaining <= file size, index <= 0
        logic bp_rd;         // read block pointer of current index
        logic rel_latch;     // hold pointer, read its bitmap word
        logic rel_wr;        // clear the block's bit, step
        logic fs_clr;        // file size <= 0
        logic len_ld;        // remaining <= length, start block count
        logic need_step;     // count one more block needed
        logic set_too_large;
        logic set_no_space;
        logic scan_rd;       // read bitmap word under scan
        logic scan_ld;       // load free-bit mask of that word
        logic scan_next;     // advance to next bitmap word
        logic scan_pick;     // take lowest free bit as candidate
        logic claim_init;    // file size <= length, restart index
        logic claim_rd;      // read word of current candidate
        logic claim_wr;      // set its bit, store pointer
        logic emit_blk;      // present a block result, step
        logic emit_idle;     // present a result without block
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        opcode_t op;
        logic    rem_zero;
        logic    k_full;
        logic    too_large;
        logic    lim_hit;
        logic    avail_zero;
        logic    pick_done;
        logic    need_zero;
        logic    blk_last;
        logic    out_free;
    } stat_t;

    // index of the lowest set bit
    function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_AW-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_AW'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- hdl/file_block_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// file_block_bitmap_allocator
// Results leave through a registered output: release walks the held blocks;
//   read emits one transfer per block (one empty one when none); an unused
//   opcode gives one empty result; write releases, scans and claims.
// Throughput: one item at a time, the next taken once the last result is
//   registered; the first-fit scan reads one 32-bit bitmap word per step.
// Reset: synchronous, active low; bitmap and file sizes read as zero at once
//   through row valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module file_block_bitmap_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [fbba_pkg::OP_W-1:0]      s_opcode,
    input  logic [fbba_pkg::FILE_W-1:0]    s_file_index,
    input  logic [fbba_pkg::LEN_W-1:0]     s_length_bytes,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [fbba_pkg::STATUS_W-1:0]  m_status,
    output logic                           m_has_block,
    output logic [fbba_pkg::BLK_W-1:0]     m_block_number,
    output logic [fbba_pkg::BS_W-1:0]      m_byte_count,
    output logic                           m_last,
    // register write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbba_pkg::CFG_W-1:0]     cfg_data
);

    // Control/status bundles between sequencer and datapath.
    fbba_pkg::cmd_t  cmd;
    fbba_pkg::stat_t stat;

    // Register writes are always taken; the user must write them only while idle, as the block does not enforce it.
    assign cfg_ready = 1'b1;

    // Sequencer. Each request with a used opcode runs the same skeleton:
    //   - fetch the file size, walk its pointers (count = ceil(size/bs),
    //     capped at five) by repeated subtraction of the block size;
    //   - release: clear each pointed block's bit with a read-modify-write;
    //   - write: release, check length against five blocks, count blocks
    //     needed, scan the bitmap word by word collecting the lowest free
    //     bits, and only when enough are found mark them and emit one
    //     transfer per block;
    //   - read: one transfer per block with its byte count.
    // The final transfer of an item goes into the output register and the
    // sequencer is free again, so a new request can be taken while it waits.
    fbba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: stores, block arithmetic, bitmap scan and output register.
    fbba_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_opcode       (s_opcode),
        .s_file_index   (s_file_index),
        .s_length_bytes (s_length_bytes),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_has_block    (m_has_block),
        .m_block_number (m_block_number),
        .m_byte_count   (m_byte_count),
        .m_last         (m_last)
    );

endmodule

// ----- hdl/fbba_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbba_ctrl
// Sequencer: release, length check, bitmap scan, claim and read-out steps.
// ----------------------------------------------------------------------------
module fbba_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fbba_pkg::stat_t  stat,
    output fbba_pkg::cmd_t   cmd
);

    fbba_pkg::state_t state_reg;
    fbba_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fbba_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            fbba_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = fbba_pkg::S_FS_RD;
                end
            end
            fbba_pkg::S_FS_RD: begin
                if (stat.op == fbba_pkg::OP_NONE) begin
                    state_next = fbba_pkg::S_EMIT_IDLE;
                end else begin
                    cmd.fs_rd  = 1'b1;
                    state_next = fbba_pkg::S_SIZE_LD;
                end
            end
            fbba_pkg::S_SIZE_LD: begin
                cmd.size_ld = 1'b1;
                state_next  = (stat.op == fbba_pkg::OP_READ) ? fbba_pkg::S_RD_CHK
                                                             : fbba_pkg::S_REL_CHK;
            end
            fbba_pkg::S_REL_CHK: begin
                if (stat.rem_zero || stat.k_full) begin
                    state_next = fbba_pkg::S_REL_DONE;
                end else begin
                    cmd.bp_rd  = 1'b1;
                    state_next = fbba_pkg::S_REL_PTR;
                end
            end
            fbba_pkg::S_REL_PTR: begin
                cmd.rel_latch = 1'b1;
                state_next    = fbba_pkg::S_REL_MAP;
            end
            fbba_pkg::S_REL_MAP: begin
                cmd.rel_wr = 1'b1;
                state_next = fbba_pkg::S_REL_CHK;
            end
            fbba_pkg::S_REL_DONE: begin
                cmd.fs_clr = 1'b1;
                state_next = (stat.op == fbba_pkg::OP_RELEASE) ? fbba_pkg::S_EMIT_IDLE
                                                               : fbba_pkg::S_LEN_CHK;
            end
            fbba_pkg::S_LEN_CHK: begin
                if (stat.too_large) begin
                    cmd.set_too_large = 1'b1;
                    state_next        = fbba_pkg::S_EMIT_IDLE;
                end else begin
                    cmd.len_ld = 1'b1;
                    state_next = fbba_pkg::S_NEED;
                end
            end
            fbba_pkg::S_NEED: begin
                if (!stat.rem_zero) begin
                    cmd.need_step = 1'b1;
                end else if (stat.need_zero) begin
                    state_next = fbba_pkg::S_EMIT_IDLE;
                end else begin
                    state_next = fbba_pkg::S_SCAN_RD;
                end
            end
            fbba_pkg::S_SCAN_RD: begin
                if (stat.lim_hit) begin
                    cmd.set_no_space = 1'b1;
                    state_next       = fbba_pkg::S_EMIT_IDLE;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = fbba_pkg::S_SCAN_LD;
                end
            end
            fbba_pkg::S_SCAN_LD: begin
                cmd.scan_ld = 1'b1;
                state_next  = fbba_pkg::S_SCAN_PICK;
            end
            fbba_pkg::S_SCAN_PICK: begin
                if (stat.avail_zero) begin
                    cmd.scan_next = 1'b1;
                    state_next    = fbba_pkg::S_SCAN_RD;
                end else begin
                    cmd.scan_pick = 1'b1;
                    if (stat.pick_done) begin
                        state_next = fbba_pkg::S_CLAIM_INIT;
                    end
                end
            end
            fbba_pkg::S_CLAIM_INIT: begin
                cmd.claim_init = 1'b1;
                state_next     = fbba_pkg::S_CLAIM_RD;
            end
            fbba_pkg::S_CLAIM_RD: begin
                cmd.claim_rd = 1'b1;
                state_next   = fbba_pkg::S_CLAIM_WR;
            end
            fbba_pkg::S_CLAIM_WR: begin
                cmd.claim_wr = 1'b1;
                state_next   = fbba_pkg::S_CLAIM_EMIT;
            end
            fbba_pkg::S_CLAIM_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_blk = 1'b1;
                    state_next   = stat.blk_last ? fbba_pkg::S_IDLE : fbba_pkg::S_CLAIM_RD;
                end
            end
            fbba_pkg::S_RD_CHK: begin
                if (stat.rem_zero) begin
                    state_next = fbba_pkg::S_EMIT_IDLE;
                end else begin
                    cmd.bp_rd  = 1'b1;
                    state_next = fbba_pkg::S_RD_EMIT;
                end
            end
            fbba_pkg::S_RD_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_blk = 1'b1;
                    state_next   = stat.blk_last ? fbba_pkg::S_IDLE : fbba_pkg::S_RD_CHK;
                end
            end
            fbba_pkg::S_EMIT_IDLE: begin
                if (stat.out_free) begin
                    cmd.emit_idle = 1'b1;
                    state_next    = fbba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fbba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/fbba_dp.sv -----
// ----------------------------------------------------------------------------
// fbba_dp
// Datapath: configuration, stores (file size, block pointers, free bitmap),
// block arithmetic, bitmap scan and output register.
// ----------------------------------------------------------------------------
module fbba_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fbba_pkg::cmd_t                 cmd,
    output fbba_pkg::stat_t                stat,
    input  logic [fbba_pkg::OP_W-1:0]      s_opcode,
    input  logic [fbba_pkg::FILE_W-1:0]    s_file_index,
    input  logic [fbba_pkg::LEN_W-1:0]     s_length_bytes,
    input  logic                           cfg_valid,
    input  logic [fbba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbba_pkg::CFG_W-1:0]     cfg_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [fbba_pkg::STATUS_W-1:0]  m_status,
    output logic                           m_has_block,
    output logic [fbba_pkg::BLK_W-1:0]     m_block_number,
    output logic [fbba_pkg::BS_W-1:0]      m_byte_count,
    output logic                           m_last
);

    // configuration
    logic [fbba_pkg::BS_W-1:0]  bs_cfg_reg;
    logic [fbba_pkg::LIM_W-1:0] usable_cfg_reg;
    logic [fbba_pkg::BS_W-1:0]  bs;
    logic [fbba_pkg::LIM_W-1:0] lim;

    // item
    fbba_pkg::opcode_t           op_reg;
    fbba_pkg::status_t           status_reg;
    logic [fbba_pkg::FILE_W-1:0] file_reg;
    logic [fbba_pkg::LEN_W-1:0]  len_reg;

    // working registers
    logic [fbba_pkg::LEN_W-1:0]  rem_reg;
    logic [fbba_pkg::K_W-1:0]    k_reg;
    logic [fbba_pkg::K_W-1:0]    need_reg;
    logic [fbba_pkg::WIDX_W-1:0] widx_reg;
    logic [fbba_pkg::WORD_W-1:0] avail_reg;
    logic [fbba_pkg::BLK_W-1:0]  blk_reg;
    logic [fbba_pkg::BLK_W-1:0]  cand_reg [fbba_pkg::POINTERS];

    // stores
    logic [fbba_pkg::FSIZE_W-1:0] fs_mem [fbba_pkg::FILES];
    logic [fbba_pkg::FILES-1:0]   fs_vld_reg;
    logic [fbba_pkg::FSIZE_W-1:0] fs_q_reg;
    logic                         fs_vq_reg;
    logic                         fs_we;
    logic [fbba_pkg::FSIZE_W-1:0] fs_wdata;

    logic [fbba_pkg::BLK_W-1:0]  bp_mem [fbba_pkg::PTR_DEPTH];
    logic [fbba_pkg::BLK_W-1:0]  bp_q_reg;
    logic [fbba_pkg::PTR_AW-1:0] bp_addr;

    logic [fbba_pkg::WORD_W-1:0]    map_mem [fbba_pkg::MAP_WORDS];
    logic [fbba_pkg::MAP_WORDS-1:0] map_vld_reg;
    logic [fbba_pkg::WORD_W-1:0]    map_q_reg;
    logic                           map_vq_reg;
    logic                           map_re;
    logic [fbba_pkg::MAP_AW-1:0]    map_raddr;
    logic                           map_we;
    logic [fbba_pkg::MAP_AW-1:0]    map_waddr;
    logic [fbba_pkg::BIT_AW-1:0]    map_wbit;
    logic [fbba_pkg::WORD_W-1:0]    map_word;
    logic [fbba_pkg::WORD_W-1:0]    map_wdata;

    // arithmetic
    logic                          rem_gt_bs;
    logic [fbba_pkg::LEN_W-1:0]    rem_step;
    logic [fbba_pkg::BS_W-1:0]     blk_cnt;
    logic [fbba_pkg::LIM_W-1:0]    scan_base;
    logic [fbba_pkg::LIM_W-1:0]    lim_left;
    logic [fbba_pkg::WORD_W-1:0]   lim_mask;
    logic [fbba_pkg::BLK_W-1:0]    cand_cur;

    // output register
    logic                          m_valid_reg;
    fbba_pkg::status_t             m_status_reg;
    logic                          m_has_block_reg;
    logic [fbba_pkg::BLK_W-1:0]    m_block_number_reg;
    logic [fbba_pkg::BS_W-1:0]     m_byte_count_reg;
    logic                          m_last_reg;
    logic                          out_free;
    logic                          blk_last;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_cfg_reg     <= fbba_pkg::BS_W'(fbba_pkg::BS_RESET);
            usable_cfg_reg <= fbba_pkg::LIM_W'(fbba_pkg::USABLE_RESET);
        end else if (cfg_valid) begin
            unique case (fbba_pkg::cfg_reg_t'(cfg_index))
                fbba_pkg::CFG_BLOCK_SIZE: bs_cfg_reg     <= cfg_data;
                fbba_pkg::CFG_USABLE:     usable_cfg_reg <= cfg_data[fbba_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize clamps
    always_comb begin
        if (bs_cfg_reg == '0) begin
            bs = fbba_pkg::BS_W'(1);
        end else if (bs_cfg_reg > fbba_pkg::BS_W'(fbba_pkg::BS_MAX)) begin
            bs = fbba_pkg::BS_W'(fbba_pkg::BS_MAX);
        end else begin
            bs = bs_cfg_reg;
        end
        if (usable_cfg_reg > fbba_pkg::LIM_W'(fbba_pkg::DATA_BLOCKS)) begin
            lim = fbba_pkg::LIM_W'(fbba_pkg::DATA_BLOCKS);
        end else begin
            lim = usable_cfg_reg;
        end
    end

    // ---------------------------------------------------------------- arithmetic
    assign rem_gt_bs = rem_reg > fbba_pkg::LEN_W'(bs);
    assign rem_step  = rem_gt_bs ? rem_reg - fbba_pkg::LEN_W'(bs) : '0;
    assign blk_cnt   = rem_gt_bs ? bs : rem_reg[fbba_pkg::BS_W-1:0];
    assign cand_cur  = cand_reg[k_reg];

    assign scan_base = fbba_pkg::LIM_W'(widx_reg) << fbba_pkg::BIT_AW;
    assign lim_left  = lim - scan_base;
    always_comb begin
        if (lim_left >= fbba_pkg::LIM_W'(fbba_pkg::WORD_W)) begin
            lim_mask = '1;
        end else begin
            lim_mask = ~({fbba_pkg::WORD_W{1'b1}} << lim_left[fbba_pkg::BIT_AW-1:0]);
        end
    end

    assign bp_addr = fbba_pkg::PTR_AW'(file_reg) * fbba_pkg::PTR_AW'(fbba_pkg::POINTERS)
                   + fbba_pkg::PTR_AW'(k_reg);

    // ---------------------------------------------------------------- file size store
    assign fs_we    = cmd.fs_clr | cmd.claim_init;
    assign fs_wdata = cmd.claim_init ? len_reg[fbba_pkg::FSIZE_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (cmd.fs_rd) begin
            fs_q_reg <= fs_mem[file_reg[fbba_pkg::FS_AW-1:0]];
        end
        if (fs_we) begin
            fs_mem[file_reg[fbba_pkg::FS_AW-1:0]] <= fs_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_vld_reg <= '0;
            fs_vq_reg  <= 1'b0;
        end else begin
            if (cmd.fs_rd) begin
                fs_vq_reg <= fs_vld_reg[file_reg[fbba_pkg::FS_AW-1:0]];
            end
            if (fs_we) begin
                fs_vld_reg[file_reg[fbba_pkg::FS_AW-1:0]] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- pointer store
    always_ff @(posedge aclk) begin
        if (cmd.bp_rd) begin
            bp_q_reg <= bp_mem[bp_addr];
        end
        if (cmd.claim_wr) begin
            bp_mem[bp_addr] <= cand_cur;
        end
    end

    // ---------------------------------------------------------------- free bitmap
    assign map_re = cmd.rel_latch | cmd.scan_rd | cmd.claim_rd;
    always_comb begin
        if (cmd.rel_latch) begin
            map_raddr = bp_q_reg[fbba_pkg::BIT_AW +: fbba_pkg::MAP_AW];
        end else if (cmd.scan_rd) begin
            map_raddr = widx_reg[fbba_pkg::MAP_AW-1:0];
        end else begin
            map_raddr = cand_cur[fbba_pkg::BIT_AW +: fbba_pkg::MAP_AW];
        end
    end

    assign map_word = map_vq_reg ? map_q_reg : '0;
    assign map_we   = cmd.rel_wr | cmd.claim_wr;
    always_comb begin
        if (cmd.rel_wr) begin
            map_waddr = blk_reg[fbba_pkg::BIT_AW +: fbba_pkg::MAP_AW];
            map_wbit  = blk_reg[fbba_pkg::BIT_AW-1:0];
            map_wdata = map_word & ~(fbba_pkg::WORD_W'(1) << map_wbit);
        end else begin
            map_waddr = cand_cur[fbba_pkg::BIT_AW +: fbba_pkg::MAP_AW];
            map_wbit  = cand_cur[fbba_pkg::BIT_AW-1:0];
            map_wdata = map_word | (fbba_pkg::WORD_W'(1) << map_wbit);
        end
    end

    always_ff @(posedge aclk) begin
        if (map_re) begin
            map_q_reg <= map_mem[map_raddr];
        end
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_vld_reg <= '0;
            map_vq_reg  <= 1'b0;
        end else begin
            if (map_re) begin
                map_vq_reg <= map_vld_reg[map_raddr];
            end
            if (map_we) begin
                map_vld_reg[map_waddr] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- item and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg     <= fbba_pkg::OP_NONE;
            status_reg <= fbba_pkg::STATUS_OK;
            k_reg      <= '0;
            need_reg   <= '0;
            widx_reg   <= '0;
        end else begin
            if (cmd.load) begin
                op_reg     <= fbba_pkg::opcode_t'(s_opcode);
                status_reg <= fbba_pkg::STATUS_OK;
            end
            if (cmd.set_too_large) begin
                status_reg <= fbba_pkg::STATUS_TOO_LARGE;
            end
            if (cmd.set_no_space) begin
                status_reg <= fbba_pkg::STATUS_NO_SPACE;
            end
            if (cmd.size_ld || cmd.len_ld || cmd.claim_init) begin
                k_reg <= '0;
            end else if (cmd.rel_wr || cmd.scan_pick || cmd.emit_blk) begin
                k_reg <= k_reg + fbba_pkg::K_W'(1);
            end
            if (cmd.len_ld) begin
                need_reg <= '0;
                widx_reg <= '0;
            end
            if (cmd.need_step) begin
                need_reg <= need_reg + fbba_pkg::K_W'(1);
            end
            if (cmd.scan_next) begin
                widx_reg <= widx_reg + fbba_pkg::WIDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            file_reg <= s_file_index;
            len_reg  <= s_length_bytes;
        end
        if (cmd.size_ld) begin
            rem_reg <= fs_vq_reg ? fbba_pkg::LEN_W'(fs_q_reg) : '0;
        end else if (cmd.len_ld || cmd.claim_init) begin
            rem_reg <= len_reg;
        end else if (cmd.rel_wr || cmd.need_step || cmd.emit_blk) begin
            rem_reg <= rem_step;
        end
        if (cmd.rel_latch) begin
            blk_reg <= bp_q_reg;
        end
        if (cmd.scan_ld) begin
            avail_reg <= ~map_word & lim_mask;
        end else if (cmd.scan_pick) begin
            avail_reg <= avail_reg & (avail_reg - fbba_pkg::WORD_W'(1));
        end
        if (cmd.scan_pick) begin
            cand_reg[k_reg] <= fbba_pkg::BLK_W'({widx_reg[fbba_pkg::MAP_AW-1:0],
                                                 fbba_pkg::lowest_set(avail_reg)});
        end
    end

    // ---------------------------------------------------------------- output register
    assign out_free = !m_valid_reg || m_ready;
    assign blk_last = (op_reg == fbba_pkg::OP_WRITE)
                    ? (k_reg + fbba_pkg::K_W'(1) == need_reg)
                    : (!rem_gt_bs || k_reg == fbba_pkg::K_W'(fbba_pkg::POINTERS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_blk || cmd.emit_idle) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_idle) begin
            m_status_reg       <= status_reg;
            m_has_block_reg    <= 1'b0;
            m_block_number_reg <= '0;
            m_byte_count_reg   <= '0;
            m_last_reg         <= 1'b1;
        end else if (cmd.emit_blk) begin
            m_status_reg       <= fbba_pkg::STATUS_OK;
            m_has_block_reg    <= 1'b1;
            m_block_number_reg <= (op_reg == fbba_pkg::OP_WRITE) ? cand_cur : bp_q_reg;
            m_byte_count_reg   <= blk_cnt;
            m_last_reg         <= blk_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_has_block    = m_has_block_reg;
    assign m_block_number = m_block_number_reg;
    assign m_byte_count   = m_byte_count_reg;
    assign m_last         = m_last_reg;

    // ---------------------------------------------------------------- status
    always_comb begin
        stat            = '0;
        stat.op         = op_reg;
        stat.rem_zero   = rem_reg == '0;
        stat.k_full     = k_reg == fbba_pkg::K_W'(fbba_pkg::POINTERS);
        stat.too_large  = (fbba_pkg::LEN_W+1)'(len_reg)
                        > (fbba_pkg::LEN_W+1)'(bs) * (fbba_pkg::LEN_W+1)'(fbba_pkg::POINTERS);
        stat.lim_hit    = scan_base >= lim;
        stat.avail_zero = avail_reg == '0;
        stat.pick_done  = k_reg + fbba_pkg::K_W'(1) == need_reg;
        stat.need_zero  = need_reg == '0;
        stat.blk_last   = blk_last;
        stat.out_free   = out_free;
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the file block bitmap allocator. A mirror of the
// free bitmap, file sizes and block pointers predicts every result of each
// accepted request. Directed requests come first, then random write/read/
// release sequences under a series of block size and usable-block settings,
// with random idle bursts on both channels in all but the last setting.
// ----------------------------------------------------------------------------
module testbench;

    // generous cycle limit
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        fbba_pkg::opcode_t                op;
        logic [fbba_pkg::FILE_W-1:0]      file_index;
        logic [fbba_pkg::LEN_W-1:0]       length;
    } file_request_t;

    typedef struct {
        fbba_pkg::status_t                status;
        logic                             has_block;
        logic [fbba_pkg::BLK_W-1:0]       block_number;
        logic [fbba_pkg::BS_W-1:0]        byte_count;
        logic                             last;
    } block_result_t;

    logic                             aclk;
    logic                             aresetn = 1'b0;

    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [fbba_pkg::OP_W-1:0]        s_opcode = '0;
    logic [fbba_pkg::FILE_W-1:0]      s_file_index = '0;
    logic [fbba_pkg::LEN_W-1:0]       s_length_bytes = '0;

    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [fbba_pkg::STATUS_W-1:0]    m_status;
    logic                             m_has_block;
    logic [fbba_pkg::BLK_W-1:0]       m_block_number;
    logic [fbba_pkg::BS_W-1:0]        m_byte_count;
    logic                             m_last;

    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [fbba_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [fbba_pkg::CFG_W-1:0]       cfg_data = '0;

    // requests waiting to be driven, results the allocator still owes
    file_request_t                    file_requests[$];
    block_result_t                    block_results_due[$];

    // mirror of the allocator's state and registers
    logic                             map_in_use [fbba_pkg::DATA_BLOCKS];
    logic [fbba_pkg::FSIZE_W-1:0]     file_bytes [fbba_pkg::FILES];
    logic [fbba_pkg::BLK_W-1:0]       file_ptrs  [fbba_pkg::PTR_DEPTH];
    logic                             ptr_written[fbba_pkg::PTR_DEPTH];
    logic [fbba_pkg::BS_W-1:0]        reg_block_size;
    logic [fbba_pkg::LIM_W-1:0]       reg_usable;

    int                               mismatches = 0;
    int                               cycles = 0;
    bit                               quiet = 1'b0;   // no idling on either side when set

    file_block_bitmap_allocator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_file_index   (s_file_index),
        .s_length_bytes (s_length_bytes),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_has_block    (m_has_block),
        .m_block_number (m_block_number),
        .m_byte_count   (m_byte_count),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Allocator mirror
    // ------------------------------------------------------------------------

    // a block size of zero behaves as one, anything past the maximum as the maximum
    function automatic int unsigned clamp_block_size(logic [fbba_pkg::BS_W-1:0] v);
        if (v == 0) return 1;
        if (v > fbba_pkg::BS_MAX) return fbba_pkg::BS_MAX;
        return 32'(v);
    endfunction

    // blocks a file of this many bytes occupies, never more than its pointers
    function automatic int unsigned blocks_held(int unsigned bytes, int unsigned bs);
        int unsigned n;
        n = (bytes + bs - 1) / bs;
        return (n > fbba_pkg::POINTERS) ? fbba_pkg::POINTERS : n;
    endfunction

    function automatic void free_file(int unsigned fi, int unsigned bs);
        int unsigned n;
        int unsigned i;
        n = blocks_held(32'(file_bytes[fi]), bs);
        for (i = 0; i < n; i++)
            map_in_use[file_ptrs[fi*fbba_pkg::POINTERS + i]] = 1'b0;
        file_bytes[fi] = '0;
    endfunction

    function automatic void queue_result(fbba_pkg::status_t st, logic has, int unsigned blk,
                                         int unsigned cnt, logic lst);
        block_result_t r;
        r.status       = st;
        r.has_block    = has;
        r.block_number = fbba_pkg::BLK_W'(blk);
        r.byte_count   = fbba_pkg::BS_W'(cnt);
        r.last         = lst;
        block_results_due.push_back(r);
    endfunction

    // applies one accepted request to the mirror and queues what it should emit
    function automatic void run_file_op(file_request_t rq);
        int unsigned bs;
        int unsigned lim;
        int unsigned need;
        int unsigned found;
        int unsigned k;
        int unsigned cnt;
        int unsigned n;
        int unsigned i;
        int unsigned fi;
        int unsigned len;
        bs  = clamp_block_size(reg_block_size);
        lim = (reg_usable > fbba_pkg::DATA_BLOCKS) ? fbba_pkg::DATA_BLOCKS : 32'(reg_usable);
        fi  = 32'(rq.file_index);
        len = 32'(rq.length);
        case (rq.op)
            fbba_pkg::OP_RELEASE: begin
                free_file(fi, bs);
                queue_result(fbba_pkg::STATUS_OK, 1'b0, 0, 0, 1'b1);
            end
            fbba_pkg::OP_WRITE: begin
                // a write always drops the old blocks, even if it then fails
                free_file(fi, bs);
                need  = (len + bs - 1) / bs;
                found = 0;
                for (i = 0; i < lim && found < need; i++)
                    if (!map_in_use[i]) found++;
                if (len > bs * fbba_pkg::POINTERS) begin
                    queue_result(fbba_pkg::STATUS_TOO_LARGE, 1'b0, 0, 0, 1'b1);
                end else if (found != need) begin
                    queue_result(fbba_pkg::STATUS_NO_SPACE, 1'b0, 0, 0, 1'b1);
                end else begin
                    file_bytes[fi] = fbba_pkg::FSIZE_W'(len);
                    if (need == 0) begin
                        queue_result(fbba_pkg::STATUS_OK, 1'b0, 0, 0, 1'b1);
                    end else begin
                        // first fit: lowest free blocks inside the usable range
                        k = 0;
                        for (i = 0; i < lim && k < need; i++) begin
                            if (!map_in_use[i]) begin
                                map_in_use[i] = 1'b1;
                                file_ptrs[fi*fbba_pkg::POINTERS + k]   = fbba_pkg::BLK_W'(i);
                                ptr_written[fi*fbba_pkg::POINTERS + k] = 1'b1;
                                cnt = len - k * bs;
                                if (cnt > bs) cnt = bs;
                                queue_result(fbba_pkg::STATUS_OK, 1'b1, i, cnt,
                                             (k + 1) == need);
                                k++;
                            end
                        end
                    end
                end
            end
            fbba_pkg::OP_READ: begin
                n = blocks_held(32'(file_bytes[fi]), bs);
                if (n == 0) begin
                    queue_result(fbba_pkg::STATUS_OK, 1'b0, 0, 0, 1'b1);
                end else begin
                    for (i = 0; i < n; i++) begin
                        cnt = 32'(file_bytes[fi]) - i * bs;
                        if (cnt > bs) cnt = bs;
                        queue_result(fbba_pkg::STATUS_OK, 1'b1,
                                     32'(file_ptrs[fi*fbba_pkg::POINTERS + i]), cnt,
                                     (i + 1) == n);
                    end
                end
            end
            default: begin
                // unused opcode: no state change, a single empty result
                queue_result(fbba_pkg::STATUS_OK, 1'b0, 0, 0, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: one transfer per accepted item, random idle bursts
    // ------------------------------------------------------------------------
    file_request_t active_req;
    int            gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            // the mirror moves on at the very edge the request is taken
            if (s_valid && s_ready)
                run_file_op(active_req);
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (file_requests.size() != 0) begin
                    active_req = file_requests.pop_front();
                    s_opcode       <= active_req.op;
                    s_file_index   <= active_req.file_index;
                    s_length_bytes <= active_req.length;
                    s_valid        <= 1'b1;
                    // idle burst after this request has gone
                    if (!quiet && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 8);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: checks each transfer against the oldest owed result,
    // and stalls the result channel in random bursts
    // ------------------------------------------------------------------------
    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    block_result_t owed;
    int            stall_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (block_results_due.size() == 0) begin
                    $error("result transfer with none owed: status %0d block %0d",
                           m_status, m_block_number);
                    mismatches++;
                end else begin
                    owed = block_results_due.pop_front();
                    compare_field("status", 16'(owed.status), 16'(m_status));
                    compare_field("has_block", 16'(owed.has_block), 16'(m_has_block));
                    compare_field("block_number", 16'(owed.block_number),
                                  16'(m_block_number));
                    compare_field("byte_count", 16'(owed.byte_count), 16'(m_byte_count));
                    compare_field("last", 16'(owed.last), 16'(m_last));
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void add_request(fbba_pkg::opcode_t op, int unsigned fi,
                                        int unsigned len);
        file_requests.push_back('{op, fbba_pkg::FILE_W'(fi), fbba_pkg::LEN_W'(len)});
    endfunction

    // mostly a handful of files so that reads and releases hit held blocks
    function automatic int unsigned pick_file();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, fbba_pkg::FILES - 1)
                                           : $urandom_range(0, 7);
    endfunction

    // lengths mostly fit the pointers; a few land on the edge or far beyond
    function automatic int unsigned pick_length();
        int unsigned cap;
        int unsigned r;
        cap = clamp_block_size(reg_block_size) * fbba_pkg::POINTERS;
        r   = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(0, 65535);
        if (r == 1) return cap;
        if (r == 2) return cap + 1;
        return $urandom_range(0, cap);
    endfunction

    // every owed result has come back and nothing is left to send
    task automatic wait_idle();
        do @(negedge aclk);
        while (file_requests.size() != 0 || s_valid || block_results_due.size() != 0);
    endtask

    task automatic write_reg(fbba_pkg::cfg_reg_t idx, logic [fbba_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == fbba_pkg::CFG_BLOCK_SIZE)
            reg_block_size = val;
        else
            reg_usable = val[fbba_pkg::LIM_W-1:0];
    endtask

    // one setting of both registers followed by a burst of random traffic
    task automatic run_phase(logic [fbba_pkg::CFG_W-1:0] bs_val,
                             logic [fbba_pkg::CFG_W-1:0] usable_val,
                             int n_items, bit no_idle);
        int unsigned       fi;
        int unsigned       n;
        int unsigned       i;
        int unsigned       r;
        int                made;
        bit                stale;
        fbba_pkg::opcode_t op;
        wait_idle();
        // A new block size can stretch a held file over pointers never stored;
        // such files are released first, while the old size still applies.
        for (fi = 0; fi < fbba_pkg::FILES; fi++) begin
            n = blocks_held(32'(file_bytes[fi]), clamp_block_size(bs_val));
            stale = 1'b0;
            for (i = 0; i < n; i++)
                if (!ptr_written[fi*fbba_pkg::POINTERS + i]) stale = 1'b1;
            if (stale)
                add_request(fbba_pkg::OP_RELEASE, fi, $urandom_range(0, 65535));
        end
        wait_idle();
        quiet = no_idle;
        write_reg(fbba_pkg::CFG_BLOCK_SIZE, bs_val);
        write_reg(fbba_pkg::CFG_USABLE, usable_val);
        @(negedge aclk);
        made = 0;
        while (made < n_items) begin
            fi = pick_file();
            if ($urandom_range(0, 9) < 7) begin
                // write, read back, and now and then give the blocks up
                add_request(fbba_pkg::OP_WRITE, fi, pick_length());
                add_request(fbba_pkg::OP_READ, fi, $urandom_range(0, 65535));
                made += 2;
                if ($urandom_range(0, 1) == 1) begin
                    add_request(fbba_pkg::OP_RELEASE, fi, $urandom_range(0, 65535));
                    made++;
                end
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35)      op = fbba_pkg::OP_WRITE;
                else if (r < 60) op = fbba_pkg::OP_READ;
                else if (r < 90) op = fbba_pkg::OP_RELEASE;
                else             op = fbba_pkg::OP_NONE;
                add_request(op, fi, pick_length());
                made++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < fbba_pkg::DATA_BLOCKS; i++) map_in_use[i] = 1'b0;
        for (int i = 0; i < fbba_pkg::FILES; i++) file_bytes[i] = '0;
        for (int i = 0; i < fbba_pkg::PTR_DEPTH; i++) begin
            file_ptrs[i]   = '0;
            ptr_written[i] = 1'b0;
        end
        reg_block_size = fbba_pkg::BS_W'(fbba_pkg::BS_RESET);
        reg_usable     = fbba_pkg::LIM_W'(fbba_pkg::USABLE_RESET);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed requests under the reset settings (2048-byte blocks)
        add_request(fbba_pkg::OP_WRITE, 0, 0);        // empty file: no blocks claimed
        add_request(fbba_pkg::OP_READ, 0, 0);         // nothing held
        add_request(fbba_pkg::OP_WRITE, 1, 1);        // single byte, one block
        add_request(fbba_pkg::OP_WRITE, 2, 10240);    // exactly all five pointers
        add_request(fbba_pkg::OP_WRITE, 3, 10241);    // one byte too many
        add_request(fbba_pkg::OP_WRITE, 63, 65535);   // widest length, too large
        add_request(fbba_pkg::OP_READ, 2, 0);
        add_request(fbba_pkg::OP_READ, 1, 65535);
        add_request(fbba_pkg::OP_RELEASE, 2, 0);
        add_request(fbba_pkg::OP_WRITE, 63, 4097);    // refills the freed low blocks
        add_request(fbba_pkg::OP_READ, 63, 0);
        add_request(fbba_pkg::OP_NONE, 5, 65535);     // unused opcode
        add_request(fbba_pkg::OP_RELEASE, 10, 0);     // release of an empty file
        add_request(fbba_pkg::OP_WRITE, 1, 2048);     // rewrite frees the old block first
        add_request(fbba_pkg::OP_READ, 1, 0);
        add_request(fbba_pkg::OP_READ, 3, 0);         // failed write left it empty
        add_request(fbba_pkg::OP_RELEASE, 63, 0);

        // block size, usable blocks (upper data bits set on the first), items
        run_phase(13'd1,    13'h1810, 26, 1'b0);
        run_phase(13'd0,    13'd0,    20, 1'b0);
        run_phase(13'd4096, 13'd2047, 30, 1'b0);
        run_phase(13'd8191, 13'd1,    20, 1'b0);
        run_phase(13'd100,  13'd40,   30, 1'b0);
        run_phase(13'd7,    13'd1024, 26, 1'b0);
        run_phase(13'd2048, 13'd12,   30, 1'b1);

        wait_idle();
        // allow a stray late transfer to show up before the verdict
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
